// ===== hw/rtl/fupa_pkg.sv =====
// ----------------------------------------------------------------------------
// fupa_pkg
// Types and codes shared by the fixed unit pool allocator and its checker.
// ----------------------------------------------------------------------------
package fupa_pkg;

    localparam int KIND_W     = 2;
    localparam int UIDX_W     = 12;
    localparam int STATUS_W   = 3;
    localparam int GRANT_W    = 10;
    localparam int TOTAL_W    = 27;
    localparam int COUNT_W    = 11;
    localparam int SIZE_W     = 17;
    localparam int STRIDE_W   = SIZE_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = SIZE_W;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_INIT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GET  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PUT  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DISABLED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_READY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_SIZE  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              use_pool;
        logic [UIDX_W-1:0] unit_index;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [GRANT_W-1:0]  granted_index;
        logic [TOTAL_W-1:0]  payload_offset;
        logic [TOTAL_W-1:0]  allocated_bytes;
        logic [TOTAL_W-1:0]  free_bytes;
    } out_item_t;

    typedef enum logic [2:0] {
        S_RST_CLR,
        S_IDLE,
        S_GET,
        S_PUT,
        S_INIT_CLR,
        S_EMIT
    } state_t;

endpackage

// ===== hw/rtl/fixed_unit_pool_allocator_top.sv =====
// ----------------------------------------------------------------------------
// fixed_unit_pool_allocator_top
// Fixed-size unit pool: LIFO free stack and allocated map in on-chip memory.
// ----------------------------------------------------------------------------
// Usage:
//   in_item  (valid/ready): kind = init, get or put of a unit.
//   out_item (valid/ready): exactly one result per item, in order.
//   cfg_*    (valid/ready): register writes, always ready; write only while
//                           the block is idle.
// Path from accept to result register:
//   refused get, put outside the pool, unused kind: decided in the idle state
//   get, put: stack or map read, then write back
//   init: one sweep over all MAX_UNITS entries
// The single read-modify-write on the memories sets the pace: each item is
// finished before the next is accepted, refusals included.
// Reset: a clearing pass walks the allocated map over all MAX_UNITS entries
// with in_ready low; configuration writes are taken during it.
// Stall: the result register plus a one-entry hold let the next item be
// accepted while a result waits; with both full the block holds in_ready low.
// ----------------------------------------------------------------------------
module fixed_unit_pool_allocator_top
    import fupa_pkg::*;
#(
    parameter int MAX_UNITS    = 1024,
    parameter int HEADER_BYTES = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W  = $clog2(MAX_UNITS);
    localparam int TOP_W  = $clog2(MAX_UNITS + 1);
    localparam int IPRD_W = TOP_W + STRIDE_W;
    localparam int OPRD_W = IDX_W + STRIDE_W;

    localparam logic [IDX_W-1:0] LAST_ENTRY = IDX_W'(MAX_UNITS - 1);

    function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                   input logic [SIZE_W-1:0]  b);
        logic [TOTAL_W:0] s;
        s = {1'b0, a} + (TOTAL_W + 1)'(b);
        return s[TOTAL_W] ? TOTAL_MAX : s[TOTAL_W-1:0];
    endfunction

    function automatic logic [TOTAL_W-1:0] sat_sub(input logic [TOTAL_W-1:0] a,
                                                   input logic [SIZE_W-1:0]  b);
        return (a > TOTAL_W'(b)) ? a - TOTAL_W'(b) : '0;
    endfunction

    // configuration
    logic               pool_ready_reg;
    logic [COUNT_W-1:0] unit_count_reg;
    logic [SIZE_W-1:0]  unit_size_reg;

    // control state
    state_t             state_reg, state_next;
    logic [TOP_W-1:0]   top_reg, top_next;
    logic [TOTAL_W-1:0] alloc_total_reg, alloc_total_next;
    logic [TOTAL_W-1:0] free_total_reg, free_total_next;
    logic [IDX_W-1:0]   sweep_reg, sweep_next;
    logic               out_valid_reg, out_valid_next;

    // payload registers
    logic [IDX_W-1:0]   idx_reg, idx_next;
    out_item_t          out_item_reg, out_item_next;
    out_item_t          hold_reg, hold_next;

    // memories
    logic [IDX_W-1:0]   stack_mem [MAX_UNITS];
    logic               map_mem   [MAX_UNITS];
    logic [IDX_W-1:0]   stack_rd_reg;
    logic               map_rd_reg;

    logic               stack_we, stack_re, map_we, map_re, map_wdata;
    logic [IDX_W-1:0]   stack_addr, stack_wdata, map_addr;

    logic [TOP_W-1:0]   n_pool;
    logic [STRIDE_W-1:0] stride;
    logic [IPRD_W-1:0]  init_prod;
    logic [OPRD_W-1:0]  off_prod;
    logic [63:0]        off_full;
    logic               fin, out_free;
    out_item_t          res;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign n_pool = (32'(unit_count_reg) > MAX_UNITS) ? TOP_W'(MAX_UNITS)
                                                      : TOP_W'(unit_count_reg);
    assign stride    = STRIDE_W'(unit_size_reg) + STRIDE_W'(HEADER_BYTES);
    assign init_prod = IPRD_W'(n_pool) * IPRD_W'(stride);
    assign off_prod  = OPRD_W'(stack_rd_reg) * OPRD_W'(stride);
    assign off_full  = 64'(off_prod) + 64'(HEADER_BYTES);
    assign out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            pool_ready_reg <= 1'b0;
            unit_count_reg <= COUNT_W'(1024);
            unit_size_reg  <= SIZE_W'(64);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_POOL_READY: pool_ready_reg <= cfg_data[0];
                CFG_UNIT_COUNT: unit_count_reg <= cfg_data[COUNT_W-1:0];
                CFG_UNIT_SIZE:  unit_size_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next       = state_reg;
        top_next         = top_reg;
        alloc_total_next = alloc_total_reg;
        free_total_next  = free_total_reg;
        sweep_next       = sweep_reg;
        idx_next         = idx_reg;
        hold_next        = hold_reg;
        out_item_next    = out_item_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        stack_we         = 1'b0;
        stack_re         = 1'b0;
        stack_addr       = sweep_reg;
        stack_wdata      = sweep_reg;
        map_we           = 1'b0;
        map_re           = 1'b0;
        map_addr         = sweep_reg;
        map_wdata        = 1'b0;
        fin              = 1'b0;
        res              = '0;

        case (state_reg)
            S_RST_CLR, S_INIT_CLR:
            begin
                // init and the reset pass rewrite every stack entry with its own index and clear the map
                stack_we = 1'b1;
                map_we   = 1'b1;
                if (sweep_reg == LAST_ENTRY)
                begin
                    if (state_reg == S_INIT_CLR)
                        fin = 1'b1;
                    else
                        state_next = S_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_item.kind)
                        KIND_INIT:
                        begin
                            top_next         = n_pool;
                            alloc_total_next = '0;
                            free_total_next  = (64'(init_prod) > 64'(TOTAL_MAX)) ?
                                               TOTAL_MAX : TOTAL_W'(init_prod);
                            sweep_next       = '0;
                            state_next       = S_INIT_CLR;
                        end
                        KIND_GET:
                        begin
                            if (!in_item.use_pool || !pool_ready_reg)
                            begin
                                fin        = 1'b1;
                                res.status = ST_DISABLED;
                            end
                            else if (top_reg == '0)
                            begin
                                fin        = 1'b1;
                                res.status = ST_EMPTY;
                            end
                            else
                            begin
                                stack_re   = 1'b1;
                                stack_addr = IDX_W'(top_reg - 1'b1);
                                state_next = S_GET;
                            end
                        end
                        KIND_PUT:
                        begin
                            if (!pool_ready_reg ||
                                32'(in_item.unit_index) >= 32'(n_pool))
                            begin
                                fin        = 1'b1;
                                res.status = ST_OUTSIDE;
                            end
                            else
                            begin
                                map_re     = 1'b1;
                                map_addr   = IDX_W'(in_item.unit_index);
                                idx_next   = IDX_W'(in_item.unit_index);
                                state_next = S_PUT;
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_GET:
            begin
                map_we            = 1'b1;
                map_addr          = stack_rd_reg;
                map_wdata         = 1'b1;
                top_next          = top_reg - 1'b1;
                alloc_total_next  = sat_add(alloc_total_reg, unit_size_reg);
                free_total_next   = sat_sub(free_total_reg, unit_size_reg);
                res.granted_index  = GRANT_W'(stack_rd_reg);
                res.payload_offset = TOTAL_W'(off_full);
                fin               = 1'b1;
            end
            S_PUT:
            begin
                fin = 1'b1;
                if (!map_rd_reg || 32'(top_reg) >= MAX_UNITS)
                begin
                    res.status = ST_NOT_ALLOC;
                end
                else
                begin
                    map_we           = 1'b1;
                    map_addr         = idx_reg;
                    stack_we         = 1'b1;
                    stack_addr       = IDX_W'(top_reg);
                    stack_wdata      = idx_reg;
                    top_next         = top_reg + 1'b1;
                    free_total_next  = sat_add(free_total_reg, unit_size_reg);
                    alloc_total_next = sat_sub(alloc_total_reg, unit_size_reg);
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_item_next  = hold_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res.allocated_bytes = alloc_total_next;
        res.free_bytes      = free_total_next;

        if (fin)
        begin
            if (out_free)
            begin
                out_item_next  = res;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            else
            begin
                hold_next  = res;
                state_next = S_EMIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg       <= S_RST_CLR;
            top_reg         <= '0;
            alloc_total_reg <= '0;
            free_total_reg  <= '0;
            sweep_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            top_reg         <= top_next;
            alloc_total_reg <= alloc_total_next;
            free_total_reg  <= free_total_next;
            sweep_reg       <= sweep_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        idx_reg      <= idx_next;
        hold_reg     <= hold_next;
        out_item_reg <= out_item_next;
    end

    // free stack: one port, read or write in a cycle
    always_ff @(posedge clk) begin
        if (stack_we)
            stack_mem[stack_addr] <= stack_wdata;
        if (stack_re)
            stack_rd_reg <= stack_mem[stack_addr];
    end

    // allocated map: one port, read or write in a cycle
    always_ff @(posedge clk) begin
        if (map_we)
            map_mem[map_addr] <= map_wdata;
        if (map_re)
            map_rd_reg <= map_mem[map_addr];
    end

endmodule

// ===== hw/rtl/fupa_checker.sv =====
// ----------------------------------------------------------------------------
// fupa_checker
// Port-level checks for the fixed unit pool allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fupa_checker
    import fupa_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_item
);

    // a waiting result stays put until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed or dropped while stalled");

    // only a granted unit carries an index and offset
    a_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.status != ST_OK) |->
            (out_item.granted_index == '0) && (out_item.payload_offset == '0))
        else $error("refused item reports a unit");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.status <= ST_NOT_ALLOC)
        else $error("unknown status code");

    // a new result follows an accepted item or work in progress
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready || in_valid))
        else $error("result without an item");

endmodule

bind fixed_unit_pool_allocator_top fupa_checker u_fupa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);
